FILE: rtl/core/dtpm_pkg.sv
// Shared constants and types for the decimal digit trie prefix matcher.
// No dependencies; imported by digit_trie_prefix_match_top.
`timescale 1ns / 1ps

package dtpm_pkg;

    // Field widths of the item and result channels
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 30;
    localparam int LEN_W   = 4;

    // Decimal conversion: one BCD digit per nibble, ten digits cover 30 bits
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int RADIX      = 10;

    // Default sizing
    localparam int DEF_NODE_COUNT = 1024;
    localparam int DEF_MAX_DIGITS = 9;

    // Item kinds; the fourth code changes nothing
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

endpackage

FILE: rtl/core/digit_trie_prefix_match_top.sv
// Decimal digit trie with longest-prefix match: bit-serial BCD conversion,
// digit-serial walk through a child table held in a single-port-write RAM.
// Depends on dtpm_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready  | kind[1:0], value[29:0]
//   out     | output    | out_valid / out_ready| match_len[3:0], best_len[3:0], pool_full
//
// An insert or query runs a bit-serial shift-and-add-3 conversion, then strips
// leading zero digits and normalizes, then walks the digits (table read, then
// check/allocate), then loads the result. Clear and the unused kind skip the
// conversion and walk; clear first sweeps the 10 * nodes_used entries in use.
// After reset the whole table (10 * NODE_COUNT entries) is swept, one entry a
// cycle, before the first transfer is taken.
// The result register lets the next item be taken while a result waits.
`timescale 1ns / 1ps

module digit_trie_prefix_match_top
    import dtpm_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   match_len,
    output logic [LEN_W-1:0]   best_len,
    output logic               pool_full
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int DEPTH  = NODE_COUNT * RADIX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(VALUE_W);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_CONV,
        S_NORM,
        S_RD,
        S_CHK,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   sweep_reg;
    logic [ADDR_W-1:0]   sweep_last_reg;
    logic                clr_pend_reg;
    logic [NODE_W:0]     nodes_used_reg;
    logic [LEN_W-1:0]    best_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [VALUE_W-1:0]  bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [CNT_W-1:0]    bit_cnt_reg;
    logic [LEN_W-1:0]    dig_cnt_reg;
    logic [LEN_W-1:0]    walk_left_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [LEN_W-1:0]    match_reg;
    logic                full_reg;
    logic                out_valid_reg;
    logic [LEN_W-1:0]    out_match_reg;
    logic [LEN_W-1:0]    out_best_reg;
    logic                out_full_reg;

    logic [NODE_W-1:0]   mem [DEPTH];
    logic [NODE_W-1:0]   mem_rdata_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [DIGIT_W-1:0]  top_digit;
    logic [ADDR_W-1:0]   slot_addr;
    logic [ADDR_W+3:0]   clr_span;
    logic [LEN_W-1:0]    walk_len;
    logic [LEN_W-1:0]    best_next;
    logic                pool_left;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [NODE_W-1:0]   mem_wdata;
    logic                out_load;

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
        end
    end

    // Table slot of the current node and digit: node * 10 + digit
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign slot_addr = ADDR_W'({node_reg, 3'b000}) + ADDR_W'({node_reg, 1'b0})
                     + ADDR_W'(top_digit);

    // Entries in use before a clear: nodes_used * 10
    assign clr_span = (ADDR_W+4)'({nodes_used_reg, 3'b000})
                    + (ADDR_W+4)'({nodes_used_reg, 1'b0});

    // Walk at most MAX_DIGITS leading digits
    assign walk_len = (int'(dig_cnt_reg) > MAX_DIGITS) ? LEN_W'(MAX_DIGITS) : dig_cnt_reg;

    assign pool_left = (nodes_used_reg < (NODE_W+1)'(NODE_COUNT));

    // Best after this item: only a query can raise it
    assign best_next = (kind_reg == KIND_QUERY && match_reg > best_reg) ? match_reg : best_reg;

    // Write port: zero during a sweep, new node index on allocation
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_addr;
        mem_wdata = nodes_used_reg[NODE_W-1:0];
        if (state_reg == S_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_CHK && kind_reg == KIND_INSERT
                 && mem_rdata_reg == '0 && pool_left)
        begin
            mem_we = 1'b1;
        end
    end

    // Child table: one write, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[slot_addr];
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // Sequencer: sweep, convert, normalize, walk, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            sweep_last_reg <= ADDR_W'(DEPTH - 1);
            clr_pend_reg   <= 1'b0;
            nodes_used_reg <= (NODE_W+1)'(1);
            best_reg       <= '0;
            kind_reg       <= '0;
            bin_reg        <= '0;
            bcd_reg        <= '0;
            bit_cnt_reg    <= '0;
            dig_cnt_reg    <= '0;
            walk_left_reg  <= '0;
            node_reg       <= '0;
            match_reg      <= '0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_match_reg  <= '0;
            out_best_reg   <= '0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            // Raise the result on load, drop it once transferred
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + ADDR_W'(1);
                    if (sweep_reg == sweep_last_reg)
                    begin
                        state_reg    <= clr_pend_reg ? S_EMIT : S_IDLE;
                        clr_pend_reg <= 1'b0;
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg    <= kind;
                        bin_reg     <= value;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= CNT_W'(VALUE_W - 1);
                        node_reg    <= '0;
                        match_reg   <= '0;
                        full_reg    <= 1'b0;
                        unique case (kind)
                            KIND_INSERT, KIND_QUERY:
                                state_reg <= S_CONV;
                            KIND_CLEAR:
                            begin
                                state_reg      <= S_SWEEP;
                                sweep_reg      <= '0;
                                sweep_last_reg <= ADDR_W'(clr_span - (ADDR_W+4)'(1));
                                clr_pend_reg   <= 1'b1;
                                nodes_used_reg <= (NODE_W+1)'(1);
                                best_reg       <= '0;
                            end
                            default:
                                state_reg <= S_EMIT;
                        endcase
                    end
                end

                S_CONV:
                begin
                    bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                    bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg   <= S_NORM;
                        dig_cnt_reg <= LEN_W'(BCD_DIGITS);
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
                    end
                end

                S_NORM:
                begin
                    // Strip leading zero digits, keep at least one
                    if (top_digit == '0 && dig_cnt_reg > LEN_W'(1))
                    begin
                        bcd_reg     <= {bcd_reg[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                        dig_cnt_reg <= dig_cnt_reg - LEN_W'(1);
                    end
                    else
                    begin
                        walk_left_reg <= walk_len;
                        state_reg     <= S_RD;
                    end
                end

                S_RD:
                    state_reg <= S_CHK;

                S_CHK:
                begin
                    if (mem_rdata_reg == '0
                        && (kind_reg == KIND_QUERY || !pool_left))
                    begin
                        // Path ends here, or no free node for the insert
                        full_reg  <= (kind_reg == KIND_INSERT);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (mem_rdata_reg == '0)
                        begin
                            node_reg       <= nodes_used_reg[NODE_W-1:0];
                            nodes_used_reg <= nodes_used_reg + (NODE_W+1)'(1);
                        end
                        else
                        begin
                            node_reg <= mem_rdata_reg;
                        end
                        if (kind_reg == KIND_QUERY)
                            match_reg <= match_reg + LEN_W'(1);
                        bcd_reg       <= {bcd_reg[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
                        walk_left_reg <= walk_left_reg - LEN_W'(1);
                        state_reg     <= (walk_left_reg == LEN_W'(1)) ? S_EMIT : S_RD;
                    end
                end

                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_match_reg <= match_reg;
                        out_best_reg  <= best_next;
                        out_full_reg  <= full_reg;
                        best_reg      <= best_next;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign match_len = out_match_reg;
    assign best_len  = out_best_reg;
    assign pool_full = out_full_reg;

    // The best length always covers the match length reported with it
    a_best_covers_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_len >= match_len))
        else $error("best_len below match_len");

    // An insert that ran out of nodes reports no match
    a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pool_full) |-> (match_len == '0))
        else $error("pool_full with nonzero match_len");

    // Allocation never passes the pool size and the root stays counted
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg <= (NODE_W+1)'(NODE_COUNT)) && (nodes_used_reg != '0))
        else $error("node count out of range");

    // A new node is only taken while the pool has room
    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_CHK) |-> pool_left)
        else $error("allocation with a full pool");

endmodule
